// File: hw/rtl/stp_pkg.sv
package stp_pkg;

  localparam int VAL_W  = 32;
  localparam int REG_W  = 31;
  localparam int MODE_W = 2;
  localparam int IDX_W  = 12;
  localparam int CNT_W  = 13;
  localparam int CFG_IDX_W = 2;

  localparam logic [CFG_IDX_W-1:0] CFG_INV_STEP  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_THRESHOLD = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_MODE      = 2'd2;

  localparam logic [MODE_W-1:0] MODE_NONE   = 2'd0;
  localparam logic [MODE_W-1:0] MODE_LASSO  = 2'd1;
  localparam logic [MODE_W-1:0] MODE_SCREEN = 2'd2;

  localparam logic [REG_W-1:0] INV_STEP_RESET = 31'd65536;

  typedef struct packed {
    logic signed [VAL_W-1:0] coef_old;
    logic signed [VAL_W-1:0] gradient;
    logic                    screen_flag;
    logic                    last;
  } in_t;

  typedef struct packed {
    logic signed [VAL_W-1:0] coef_step;
    logic signed [VAL_W-1:0] coef_new;
    logic                    is_zero;
    logic [IDX_W-1:0]        element_index;
    logic [IDX_W-1:0]        active_slot;
    logic [CNT_W-1:0]        active_count;
    logic                    end_of_vector;
  } out_t;

  typedef struct packed {
    logic signed [VAL_W-1:0] step;
    logic signed [VAL_W-1:0] newv;
    logic                    zero;
  } thr_res_t;

endpackage

// File: hw/rtl/stp_thresh.sv
module stp_thresh
  import stp_pkg::*;
(
  input  logic signed [VAL_W-1:0] coef_old,
  input  logic signed [63:0]      quot,
  input  logic [REG_W-1:0]        threshold,
  input  logic                    exempt,
  output thr_res_t                res
);

  localparam logic signed [64:0] SAT_MAX = 65'sh0_7FFF_FFFF;
  localparam logic signed [64:0] SAT_MIN = -65'sh0_8000_0000;

  logic signed [64:0] diff;
  logic signed [VAL_W-1:0] step;
  logic signed [VAL_W:0] st_w;
  logic signed [VAL_W:0] thr_w;
  logic signed [VAL_W-1:0] newv;

  always_comb begin
    diff = 65'(coef_old) - 65'(quot);
    if (diff > SAT_MAX) begin
      step = SAT_MAX[VAL_W-1:0];
    end else if (diff < SAT_MIN) begin
      step = SAT_MIN[VAL_W-1:0];
    end else begin
      step = diff[VAL_W-1:0];
    end
    st_w  = (VAL_W+1)'(step);
    thr_w = $signed({2'b00, threshold});
    if (exempt) begin
      newv = step;
    end else if (st_w > thr_w) begin
      newv = VAL_W'(st_w - thr_w);
    end else if (st_w < -thr_w) begin
      newv = VAL_W'(st_w + thr_w);
    end else begin
      newv = '0;
    end
    res.step = step;
    res.newv = newv;
    res.zero = (newv == '0);
  end

endmodule

// File: hw/rtl/soft_threshold_prox_step_top.sv
// channel | signals                      | beat
// input   | in_valid, in_stall, in_data  | coef_old, gradient, screen_flag, last
// output  | out_valid, out_stall, out_data | step, new coef, zero, index, slot, count, end
// config  | cfg_we, cfg_index, cfg_data  | one register write per cycle with cfg_we
// Three register stages (input, product, result); one beat per cycle while out_stall is low.
// The gradient * inv_step multiply sits alone between input and product registers.
// Counters update when a beat moves into the result register.
// Reset (rst, synchronous) empties the pipeline, clears counters, restores registers.
// Stages move up into bubbles, so an input beat is taken while a result waits.
module soft_threshold_prox_step_top
  import stp_pkg::*;
#(
  parameter int DIM_MAX   = 4096,
  parameter int FRAC_BITS = 16
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  in_t                  in_data,
  output logic                 out_valid,
  input  logic                 out_stall,
  output out_t                 out_data,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [REG_W-1:0]     cfg_data
);

  localparam int IW = (DIM_MAX > 1) ? $clog2(DIM_MAX) : 1;
  localparam int AW = $clog2(DIM_MAX + 1);
  localparam logic [IW-1:0] IDX_LAST = IW'(DIM_MAX - 1);
  localparam logic [AW-1:0] ACT_MAX  = AW'(DIM_MAX);

  logic [REG_W-1:0]  inv_step;
  logic [REG_W-1:0]  threshold;
  logic [MODE_W-1:0] intercept_mode;

  logic s0_valid, s1_valid, s2_valid;
  logic s0_go, s1_go, s2_ready, s1_ready, s0_ready;
  in_t  s0;
  logic signed [VAL_W-1:0] s1_old;
  logic signed [63:0]      s1_quot;
  logic                    s1_scr;
  logic                    s1_last;
  out_t                    s2;

  logic [IW-1:0] idx, idx_next;
  logic [AW-1:0] act, act_next;
  logic [IW-1:0] slot;
  logic          exempt;
  logic signed [VAL_W-1:0] inv_s;
  logic signed [63:0]      prod;
  thr_res_t                res;

  assign s2_ready = !s2_valid || !out_stall;
  assign s1_ready = !s1_valid || s2_ready;
  assign s0_ready = !s0_valid || s1_ready;
  assign s0_go    = s0_valid && s1_ready;
  assign s1_go    = s1_valid && s2_ready;
  assign in_stall = !s0_ready;
  assign out_valid = s2_valid;
  assign out_data  = s2;

  always_ff @(posedge clk) begin
    if (rst) begin
      inv_step       <= INV_STEP_RESET;
      threshold      <= '0;
      intercept_mode <= MODE_NONE;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_INV_STEP:  inv_step       <= cfg_data;
        CFG_THRESHOLD: threshold      <= cfg_data;
        CFG_MODE:      intercept_mode <= cfg_data[MODE_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s0_valid <= 1'b0;
    end else if (s0_ready) begin
      s0_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s0_ready && in_valid) begin
      s0 <= in_data;
    end
  end

  assign inv_s = $signed({1'b0, inv_step});
  assign prod  = s0.gradient * inv_s;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (s1_ready) begin
      s1_valid <= s0_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s0_go) begin
      s1_old  <= s0.coef_old;
      s1_quot <= prod >>> FRAC_BITS;
      s1_scr  <= s0.screen_flag;
      s1_last <= s0.last;
    end
  end

  assign exempt = (intercept_mode == MODE_LASSO && idx == '0) ||
                  (intercept_mode == MODE_SCREEN && !s1_scr);

  stp_thresh u_thresh (
    .coef_old  (s1_old),
    .quot      (s1_quot),
    .threshold (threshold),
    .exempt    (exempt),
    .res       (res)
  );

  always_comb begin
    slot     = '0;
    act_next = act;
    if (!res.zero) begin
      slot = (act < ACT_MAX) ? IW'(act) : IDX_LAST;
      if (act < ACT_MAX) begin
        act_next = act + 1'b1;
      end
    end
  end

  assign idx_next = (idx >= IDX_LAST) ? '0 : idx + 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      idx <= '0;
      act <= '0;
    end else if (s1_go) begin
      if (s1_last) begin
        idx <= '0;
        act <= '0;
      end else begin
        idx <= idx_next;
        act <= act_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else if (s2_ready) begin
      s2_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_go) begin
      s2.coef_step     <= res.step;
      s2.coef_new      <= res.newv;
      s2.is_zero       <= res.zero;
      s2.element_index <= IDX_W'(idx);
      s2.active_slot   <= IDX_W'(slot);
      s2.active_count  <= CNT_W'(act_next);
      s2.end_of_vector <= s1_last;
    end
  end

  a_act_bound: assert property (@(posedge clk) disable iff (rst) act <= ACT_MAX)
    else $error("active counter beyond DIM_MAX");

  a_zero_slot: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_data.is_zero) |-> (out_data.active_slot == '0))
    else $error("zero result carries an active slot");

  a_zero_mark: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (out_data.is_zero == (out_data.coef_new == '0)))
    else $error("zero mark disagrees with coef_new");

  a_last_clr: assert property (@(posedge clk) disable iff (rst)
    (s1_go && s1_last) |=> (idx == '0 && act == '0))
    else $error("counters not cleared after last beat");

  a_stall_full: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> (s0_valid && s1_valid && s2_valid && out_stall))
    else $error("input stalled with room in the pipeline");

endmodule
